// ===== design/salwb_pkg.sv =====
// Package for the set-associative LRU write-back cache tag model.
// Holds shared types, opcode and state codes, default sizes and a log helper.
// No dependencies.
package salwb_pkg;

	// default geometry
	localparam int unsigned SETS_DEF       = 256;
	localparam int unsigned WAYS_DEF       = 4;
	localparam int unsigned LINE_BYTES_DEF = 64;

	// fixed field widths
	localparam int unsigned ADDR_W = 64;
	localparam int unsigned CNT_W  = 32;

	// access kinds
	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_FETCH = 2'd2,
		OP_BAD   = 2'd3
	} op_t;

	// controller states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK
	} state_t;

	// request transaction
	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [1:0]        opcode;
	} req_t;

	// result transaction
	typedef struct packed {
		logic             hit;
		logic             writeback;
		logic [1:0]       way_used;
		logic             bad_kind;
		logic [CNT_W-1:0] access_count;
		logic [CNT_W-1:0] hit_count;
		logic [CNT_W-1:0] miss_count;
		logic [CNT_W-1:0] write_count;
		logic [CNT_W-1:0] writeback_count;
	} rsp_t;

	// per-access event for the statistics block
	typedef struct packed {
		logic en;
		logic hit;
		logic write;
		logic writeback;
	} evt_t;

	// floor(log2(v)), elaboration use only
	function automatic int unsigned flog2(input int unsigned v);
		int unsigned n;
		n = 0;
		for (int i = 0; i < 32; i++) begin
			if ((v >> (i + 1)) != 0) begin
				n = i + 1;
			end
		end
		return n;
	endfunction

endpackage

// ===== design/salwb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module salwb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/salwb_update.sv =====
// Set update logic: tag compare, victim choice, dirty/valid update, LRU reorder.
// Works on one packed set row; depends on salwb_pkg.
module salwb_update #(
	parameter int unsigned WAYS  = salwb_pkg::WAYS_DEF,
	parameter int unsigned TAG_W = 50,
	localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1,
	localparam int unsigned ENT_W = TAG_W + 2,
	localparam int unsigned ORD_LO = WAYS * ENT_W,
	localparam int unsigned ROW_W = ORD_LO + WAYS * WAY_W
) (
	input  logic             clear,
	input  logic             is_write,
	input  logic [TAG_W-1:0] tag,
	input  logic [ROW_W-1:0] rdata,
	output logic [ROW_W-1:0] wdata,
	output logic             hit,
	output logic             writeback,
	output logic [WAY_W-1:0] way
);

	logic [WAYS-1:0]  vld;
	logic [WAYS-1:0]  dty;
	logic [WAYS-1:0]  match;
	logic [WAY_W-1:0] ord [WAYS];
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] inv_way;
	logic             any_inv;
	logic             seen;
	logic [ROW_W-1:0] clear_row;

	// unpack the row: entry = {valid, dirty, tag}, order slot 0 is MRU
	for (genvar w = 0; w < WAYS; w++) begin : g_unpack
		assign vld[w]   = rdata[w*ENT_W + TAG_W + 1];
		assign dty[w]   = rdata[w*ENT_W + TAG_W];
		assign match[w] = vld[w] && (rdata[w*ENT_W +: TAG_W] == tag);
		assign ord[w]   = rdata[ORD_LO + w*WAY_W +: WAY_W];
		// reset row: all invalid, order 0..WAYS-1
		assign clear_row[w*ENT_W +: ENT_W]          = '0;
		assign clear_row[ORD_LO + w*WAY_W +: WAY_W] = WAY_W'(w);
	end

	// lowest matching way and lowest invalid way
	always_comb begin
		hit_way = '0;
		inv_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_W'(w);
			end
			if (!vld[w]) begin
				inv_way = WAY_W'(w);
			end
		end
		hit     = |match;
		any_inv = ~&vld;
	end

	// chosen way and dirty eviction
	always_comb begin
		priority if (hit) begin
			way = hit_way;
		end else if (any_inv) begin
			way = inv_way;
		end else begin
			way = ord[WAYS-1];
		end
		writeback = !hit && vld[way] && dty[way];
	end

	// new row contents
	always_comb begin
		wdata = rdata;
		seen  = 1'b0;
		for (int w = 0; w < WAYS; w++) begin
			if (WAY_W'(w) == way) begin
				if (hit) begin
					wdata[w*ENT_W + TAG_W] = dty[w] | is_write;
				end else begin
					wdata[w*ENT_W +: ENT_W] = {1'b1, is_write, tag};
				end
			end
		end
		// move chosen way to front, shift slots up to its old place
		wdata[ORD_LO +: WAY_W] = way;
		for (int k = 1; k < WAYS; k++) begin
			seen = seen | (ord[k-1] == way);
			wdata[ORD_LO + k*WAY_W +: WAY_W] = seen ? ord[k] : ord[k-1];
		end
		if (clear) begin
			wdata = clear_row;
		end
	end

endmodule

// ===== design/salwb_stats.sv =====
// Five saturating 32-bit statistics counters, each bumped at most once per valid access.
// Depends on salwb_pkg.
module salwb_stats (
	input  logic                       clk,
	input  logic                       arst_n,
	input  salwb_pkg::evt_t            evt,
	output logic [salwb_pkg::CNT_W-1:0] access_count,
	output logic [salwb_pkg::CNT_W-1:0] hit_count,
	output logic [salwb_pkg::CNT_W-1:0] miss_count,
	output logic [salwb_pkg::CNT_W-1:0] write_count,
	output logic [salwb_pkg::CNT_W-1:0] writeback_count
);

	logic [salwb_pkg::CNT_W-1:0] acc_q, hit_q, miss_q, wr_q, wb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			hit_q  <= '0;
			miss_q <= '0;
			wr_q   <= '0;
			wb_q   <= '0;
		end else if (evt.en) begin
			if (acc_q != '1) begin
				acc_q <= acc_q + 1'b1;
			end
			if (evt.hit && hit_q != '1) begin
				hit_q <= hit_q + 1'b1;
			end
			if (!evt.hit && miss_q != '1) begin
				miss_q <= miss_q + 1'b1;
			end
			if (evt.write && wr_q != '1) begin
				wr_q <= wr_q + 1'b1;
			end
			if (evt.writeback && wb_q != '1) begin
				wb_q <= wb_q + 1'b1;
			end
		end
	end

	assign access_count    = acc_q;
	assign hit_count       = hit_q;
	assign miss_count      = miss_q;
	assign write_count     = wr_q;
	assign writeback_count = wb_q;

endmodule

// ===== design/set_assoc_lru_writeback_cache_top.sv =====
// Top level of the set-associative LRU write-back cache tag model.
// Depends on salwb_pkg, salwb_ram, salwb_update, salwb_stats.
//
//   channel   signals             direction  handshake
//   request   start, busy, req    in         taken when start && !busy
//   result    done, rsp           out        one-cycle strobe, no backpressure
//
// For one access, the set row is read from the RAM at acceptance, then
// compared, updated and (but for OP_BAD) written back in the lookup cycle.
// busy is high during lookup, so no new access is taken until it is over.
// The result strobe and flags are registered at the end of the lookup cycle.
// After reset the set RAM is cleared one row per cycle, 2^floor(log2(SETS))
// rows in all, with busy high before the first access is taken.
module set_assoc_lru_writeback_cache_top #(
	parameter int unsigned SETS       = salwb_pkg::SETS_DEF,
	parameter int unsigned WAYS       = salwb_pkg::WAYS_DEF,
	parameter int unsigned LINE_BYTES = salwb_pkg::LINE_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  salwb_pkg::req_t req,
	output logic            done,
	output salwb_pkg::rsp_t rsp
);

	localparam int unsigned OFF_BITS = salwb_pkg::flog2(LINE_BYTES);
	localparam int unsigned IDX_BITS = salwb_pkg::flog2(SETS);
	localparam int unsigned SH       = OFF_BITS + IDX_BITS;
	localparam int unsigned TAG_W    = salwb_pkg::ADDR_W - SH;
	localparam int unsigned ROWS     = 1 << IDX_BITS;
	localparam int unsigned IDX_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
	localparam int unsigned WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned ROW_W    = WAYS * (TAG_W + 2) + WAYS * WAY_W;
	localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(ROWS - 1);

	salwb_pkg::state_t state_q, state_nx;

	logic [IDX_W-1:0] clr_idx_q;
	logic [TAG_W-1:0] tag_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [1:0]       op_s1;

	logic             accept;
	logic [IDX_W-1:0] in_idx;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [ROW_W-1:0] ram_wdata;
	logic [ROW_W-1:0] ram_rdata;
	logic             upd_hit;
	logic             upd_wb;
	logic [WAY_W-1:0] upd_way;
	logic             look_ok;
	logic             look_bad;
	salwb_pkg::evt_t  evt;

	logic             done_q;
	logic             hit_q;
	logic             wb_q;
	logic [1:0]       way_q;
	logic             bad_q;

	// address split
	assign in_idx = IDX_W'(req.address >> OFF_BITS) & IDX_MASK;
	assign accept = start && !busy;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			salwb_pkg::ST_CLEAR: begin
				if (clr_idx_q == IDX_MASK) begin
					state_nx = salwb_pkg::ST_IDLE;
				end
			end
			salwb_pkg::ST_IDLE: begin
				if (start) begin
					state_nx = salwb_pkg::ST_LOOK;
				end
			end
			salwb_pkg::ST_LOOK: state_nx = salwb_pkg::ST_IDLE;
			default: state_nx = salwb_pkg::ST_CLEAR;
		endcase
	end

	// state outputs
	always_comb begin
		busy      = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		look_ok   = 1'b0;
		look_bad  = 1'b0;
		unique case (state_q)
			salwb_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
			end
			salwb_pkg::ST_IDLE: busy = 1'b0;
			salwb_pkg::ST_LOOK: begin
				look_bad = (op_s1 == salwb_pkg::OP_BAD);
				look_ok  = !look_bad;
				ram_we   = look_ok;
			end
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= salwb_pkg::ST_CLEAR;
			clr_idx_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= (state_q == salwb_pkg::ST_LOOK);
			if (state_q == salwb_pkg::ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1 <= TAG_W'(req.address >> SH);
			idx_s1 <= in_idx;
			op_s1  <= req.opcode;
		end
	end

	// set rows: per way {valid, dirty, tag}, then LRU order
	salwb_ram #(
		.WIDTH(ROW_W),
		.DEPTH(ROWS)
	) u_set_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(in_idx),
		.rdata(ram_rdata)
	);

	salwb_update #(
		.WAYS (WAYS),
		.TAG_W(TAG_W)
	) u_update (
		.clear    (state_q == salwb_pkg::ST_CLEAR),
		.is_write (op_s1 == salwb_pkg::OP_WRITE),
		.tag      (tag_s1),
		.rdata    (ram_rdata),
		.wdata    (ram_wdata),
		.hit      (upd_hit),
		.writeback(upd_wb),
		.way      (upd_way)
	);

	// statistics
	assign evt.en        = look_ok;
	assign evt.hit       = upd_hit;
	assign evt.write     = (op_s1 == salwb_pkg::OP_WRITE);
	assign evt.writeback = upd_wb;

	salwb_stats u_stats (
		.clk            (clk),
		.arst_n         (arst_n),
		.evt            (evt),
		.access_count   (rsp.access_count),
		.hit_count      (rsp.hit_count),
		.miss_count     (rsp.miss_count),
		.write_count    (rsp.write_count),
		.writeback_count(rsp.writeback_count)
	);

	// result flags
	always_ff @(posedge clk) begin
		if (state_q == salwb_pkg::ST_LOOK) begin
			hit_q <= look_ok && upd_hit;
			wb_q  <= look_ok && upd_wb;
			way_q <= look_ok ? 2'(upd_way) : 2'd0;
			bad_q <= look_bad;
		end
	end

	assign done          = done_q;
	assign rsp.hit       = hit_q;
	assign rsp.writeback = wb_q;
	assign rsp.way_used  = way_q;
	assign rsp.bad_kind  = bad_q;

endmodule

// ===== design/salwb_checker.sv =====
// Port-level checks for the cache tag model, bound to the top level.
// Depends on salwb_pkg and set_assoc_lru_writeback_cache_top.
module salwb_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            done,
	input salwb_pkg::rsp_t rsp
);

	// every accepted transaction yields its result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result missing two cycles after acceptance");

	// no back-to-back results: one access in flight at a time
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results on consecutive cycles");

	// an ignored access reports nothing
	a_bad_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.bad_kind) |-> (!rsp.hit && !rsp.writeback && rsp.way_used == 2'd0))
		else $error("invalid access reported hit, writeback or way");

	// a hit never evicts
	a_hit_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.hit) |-> !rsp.writeback)
		else $error("writeback reported on a hit");

	// the access counter holds across an invalid access
	a_bad_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.bad_kind) |-> (rsp.access_count == $past(rsp.access_count)))
		else $error("access count changed on an invalid access");

endmodule

bind set_assoc_lru_writeback_cache_top salwb_checker u_salwb_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);
